// ===== rtl/ci32_pkg.sv =====
// Package for the checked 32-bit integer ALU: word types, opcodes, error codes
// and the pipeline stage word shared by every stage.
// Depends on nothing.
package ci32_pkg;

  localparam int DATA_W  = 32;
  localparam int LATENCY = DATA_W + 3;

  localparam logic [4:0] OP_ADD  = 5'd0;
  localparam logic [4:0] OP_SUB  = 5'd1;
  localparam logic [4:0] OP_MUL  = 5'd2;
  localparam logic [4:0] OP_DIV  = 5'd3;
  localparam logic [4:0] OP_MOD  = 5'd4;
  localparam logic [4:0] OP_LOR  = 5'd5;
  localparam logic [4:0] OP_LAND = 5'd6;
  localparam logic [4:0] OP_OR   = 5'd7;
  localparam logic [4:0] OP_XOR  = 5'd8;
  localparam logic [4:0] OP_AND  = 5'd9;
  localparam logic [4:0] OP_EQ   = 5'd10;
  localparam logic [4:0] OP_NE   = 5'd11;
  localparam logic [4:0] OP_LE   = 5'd12;
  localparam logic [4:0] OP_LT   = 5'd13;
  localparam logic [4:0] OP_GE   = 5'd14;
  localparam logic [4:0] OP_GT   = 5'd15;
  localparam logic [4:0] OP_SHL  = 5'd16;
  localparam logic [4:0] OP_SHR  = 5'd17;
  localparam logic [4:0] OP_PASS = 5'd18;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_OVF   = 2'd1;
  localparam logic [1:0] ERR_DIV0  = 2'd2;
  localparam logic [1:0] ERR_SHIFT = 2'd3;

  typedef struct packed {
    logic [4:0]               command;
    logic signed [DATA_W-1:0] left_operand;
    logic signed [DATA_W-1:0] right_operand;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic [1:0]               error_code;
  } out_word_t;

  typedef struct packed {
    logic                  valid;
    logic [4:0]            op;
    logic [DATA_W-1:0]     value;
    logic [1:0]            err;
    logic                  neg;
    logic                  sa;
    logic [DATA_W-1:0]     divisor;
    logic [DATA_W-1:0]     rem;
    logic [DATA_W-1:0]     quo;
    logic [2*DATA_W-1:0]   prod;
  } pipe_t;

endpackage

// ===== rtl/checked_int32_alu.sv =====
// Top level of the checked 32-bit integer ALU.
// Depends on ci32_pkg, ci32_front, ci32_mul, ci32_div_stage, ci32_back.
//
// Usage:
//   Drive request (command, left_operand, right_operand) and raise start; the
//   word is taken at a rising edge where start is high and busy is low. busy
//   is high only during reset, so a new word may be issued every cycle.
//   Each word gives exactly one response word, shown for one cycle with done
//   high, after the word has passed the registers of the front stage, multiply
//   stage, 32 restoring divider stages of one quotient bit each, and output
//   stage, in that order.
//   Throughput is one word per cycle outside reset; the divider chain sets the latency.
//   Responses leave in the order the words were taken. The receiver cannot
//   stall, so nothing is held back. Reset drops every word in flight and
//   clears done.
module checked_int32_alu (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  ci32_pkg::in_word_t  request,
  output logic                done,
  output ci32_pkg::out_word_t response
);
  import ci32_pkg::*;

  pipe_t chain [0:DATA_W+1];

  assign busy = rst;

  ci32_front u_front (
    .clk(clk), .rst(rst), .take(start && !busy), .request(request), .q(chain[0])
  );

  ci32_mul u_mul (.clk(clk), .rst(rst), .d(chain[0]), .q(chain[1]));

  for (genvar i = 0; i < DATA_W; i++) begin : g_div
    ci32_div_stage u_div (.clk(clk), .rst(rst), .d(chain[i+1]), .q(chain[i+2]));
  end

  ci32_back u_back (
    .clk(clk), .rst(rst), .d(chain[DATA_W+1]), .done(done), .response(response)
  );

endmodule

// ===== rtl/ci32_front.sv =====
// First stage: decode, simple operations, shifts, comparisons, magnitudes.
// Depends on ci32_pkg.
module ci32_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  ci32_pkg::in_word_t request,
  output ci32_pkg::pipe_t  q
);
  import ci32_pkg::*;

  logic [DATA_W-1:0] ua, ub, sum, dif, shl_r, shl_chk, shr_r;
  logic              sa, sb, bad_cnt, lt_ab, lt_ba;
  logic [$clog2(DATA_W)-1:0] n;
  pipe_t d;

  always_comb begin
    ua      = request.left_operand;
    ub      = request.right_operand;
    sa      = ua[DATA_W-1];
    sb      = ub[DATA_W-1];
    sum     = ua + ub;
    dif     = ua - ub;
    n       = ub[$clog2(DATA_W)-1:0];
    bad_cnt = (ub[DATA_W-1:$clog2(DATA_W)] != '0);
    shl_r   = ua << n;
    shl_chk = $signed(shl_r) >>> n;
    shr_r   = $signed(ua) >>> n;
    lt_ab   = $signed(ua) < $signed(ub);
    lt_ba   = $signed(ub) < $signed(ua);
    d         = '0;
    d.valid   = take && !rst;
    d.op      = request.command;
    d.neg     = sa ^ sb;
    d.sa      = sa;
    d.quo     = sa ? (~ua + 1'b1) : ua;
    d.divisor = sb ? (~ub + 1'b1) : ub;
    case (request.command)
      OP_ADD: begin
        d.value = sum;
        if ((ua[DATA_W-1] ^ sum[DATA_W-1]) & (ub[DATA_W-1] ^ sum[DATA_W-1])) d.err = ERR_OVF;
      end
      OP_SUB: begin
        d.value = dif;
        if ((ua[DATA_W-1] ^ ub[DATA_W-1]) & (ua[DATA_W-1] ^ dif[DATA_W-1])) d.err = ERR_OVF;
      end
      OP_DIV, OP_MOD: begin
        if (ub == '0) d.err = ERR_DIV0;
        else if (ua == {1'b1, {(DATA_W-1){1'b0}}} && ub == '1) d.err = ERR_OVF;
      end
      OP_LOR:  d.value = DATA_W'((ua != '0) || (ub != '0));
      OP_LAND: d.value = DATA_W'((ua != '0) && (ub != '0));
      OP_OR:   d.value = ua | ub;
      OP_XOR:  d.value = ua ^ ub;
      OP_AND:  d.value = ua & ub;
      OP_EQ:   d.value = DATA_W'(ua == ub);
      OP_NE:   d.value = DATA_W'(ua != ub);
      OP_LE:   d.value = DATA_W'(!lt_ba);
      OP_LT:   d.value = DATA_W'(lt_ab);
      OP_GE:   d.value = DATA_W'(!lt_ab);
      OP_GT:   d.value = DATA_W'(lt_ba);
      OP_SHL: begin
        if (bad_cnt) d.err = ERR_SHIFT;
        else if (shl_chk != ua) d.err = ERR_OVF;
        else d.value = shl_r;
      end
      OP_SHR: begin
        if (bad_cnt) d.err = ERR_SHIFT;
        else d.value = shr_r;
      end
      OP_PASS: d.value = ub;
      default: d.value = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= d;
  end

endmodule

// ===== rtl/ci32_mul.sv =====
// Second stage: unsigned product of the operand magnitudes.
// Depends on ci32_pkg.
module ci32_mul (
  input  logic            clk,
  input  logic            rst,
  input  ci32_pkg::pipe_t d,
  output ci32_pkg::pipe_t q
);
  import ci32_pkg::*;

  pipe_t nx;

  always_comb begin
    nx       = d;
    nx.prod  = {{DATA_W{1'b0}}, d.quo} * {{DATA_W{1'b0}}, d.divisor};
    nx.valid = d.valid && !rst;
  end

  always_ff @(posedge clk) begin
    q <= nx;
  end

endmodule

// ===== rtl/ci32_div_stage.sv =====
// One restoring division step: one quotient bit per stage.
// Depends on ci32_pkg.
module ci32_div_stage (
  input  logic            clk,
  input  logic            rst,
  input  ci32_pkg::pipe_t d,
  output ci32_pkg::pipe_t q
);
  import ci32_pkg::*;

  logic [DATA_W:0]   sh;
  logic [DATA_W+1:0] diff;
  pipe_t             nx;

  always_comb begin
    sh   = {d.rem, d.quo[DATA_W-1]};
    diff = {1'b0, sh} - {2'b00, d.divisor};
    nx   = d;
    nx.valid = d.valid && !rst;
    if (!diff[DATA_W+1]) begin
      nx.rem = diff[DATA_W-1:0];
      nx.quo = {d.quo[DATA_W-2:0], 1'b1};
    end else begin
      nx.rem = sh[DATA_W-1:0];
      nx.quo = {d.quo[DATA_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    q <= nx;
  end

endmodule

// ===== rtl/ci32_back.sv =====
// Last stage: product range check, quotient and remainder signs, error zeroing.
// Depends on ci32_pkg.
module ci32_back (
  input  logic               clk,
  input  logic               rst,
  input  ci32_pkg::pipe_t    d,
  output logic               done,
  output ci32_pkg::out_word_t response
);
  import ci32_pkg::*;

  logic [DATA_W-1:0] lim, val;
  logic [1:0]        err;

  always_comb begin
    val = d.value;
    err = d.err;
    lim = d.neg ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    case (d.op)
      OP_MUL: begin
        if (d.prod[2*DATA_W-1:DATA_W] != '0 || d.prod[DATA_W-1:0] > lim) err = ERR_OVF;
        else val = d.neg ? (~d.prod[DATA_W-1:0] + 1'b1) : d.prod[DATA_W-1:0];
      end
      OP_DIV:  val = d.neg ? (~d.quo + 1'b1) : d.quo;
      OP_MOD:  val = d.sa ? (~d.rem + 1'b1) : d.rem;
      default: val = d.value;
    endcase
    if (err != ERR_NONE) val = '0;
  end

  always_ff @(posedge clk) begin
    response.result_value <= val;
    response.error_code   <= err;
    done                  <= d.valid && !rst;
  end

endmodule

// ===== rtl/checked_int32_alu_checker.sv =====
// Port-level checker for the checked 32-bit integer ALU, with its bind.
// Depends on ci32_pkg and checked_int32_alu.
module checked_int32_alu_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input ci32_pkg::in_word_t  request,
  input logic                done,
  input ci32_pkg::out_word_t response
);
  import ci32_pkg::*;

  a_busy_reset_only: assert property (@(posedge clk) busy == rst)
    else $error("busy outside reset");

  a_reset_clears: assert property (@(posedge clk) rst |=> !done)
    else $error("done after reset");

  a_done_has_word: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("response without word");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    done && response.error_code != ERR_NONE |-> response.result_value == '0)
    else $error("nonzero result with error");

  a_shift_err: assert property (@(posedge clk) disable iff (rst)
    done && response.error_code == ERR_SHIFT |->
      ($past(request.command, LATENCY) == OP_SHL ||
       $past(request.command, LATENCY) == OP_SHR))
    else $error("shift error on non-shift");

endmodule

bind checked_int32_alu checked_int32_alu_checker u_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
  .done(done), .response(response)
);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for checked_int32_alu: directed and random words,
// predicted results held in a scoreboard class and compared with each response.
// Depends on ci32_pkg and the checked_int32_alu RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ci32_pkg::*;

  class alu_scoreboard;
    out_word_t pending[$];
    int        failures;

    function out_word_t compute(in_word_t w);
      out_word_t       o;
      logic signed [63:0] a, b, x, q;
      logic [31:0]     r;
      logic [1:0]      e;
      a = w.left_operand;
      b = w.right_operand;
      r = '0;
      e = ERR_NONE;
      case (w.command)
        OP_ADD: begin
          x = a + b;
          if (x > 64'sd2147483647 || x < -64'sd2147483648) e = ERR_OVF;
          else r = x[31:0];
        end
        OP_SUB: begin
          x = a - b;
          if (x > 64'sd2147483647 || x < -64'sd2147483648) e = ERR_OVF;
          else r = x[31:0];
        end
        OP_MUL: begin
          x = a * b;
          if (x > 64'sd2147483647 || x < -64'sd2147483648) e = ERR_OVF;
          else r = x[31:0];
        end
        OP_DIV, OP_MOD: begin
          if (b == 0) e = ERR_DIV0;
          else if (a == -64'sd2147483648 && b == -1) e = ERR_OVF;
          else begin
            q = (w.command == OP_DIV) ? a / b : a % b;
            r = q[31:0];
          end
        end
        OP_LOR:  r = 32'(a != 0 || b != 0);
        OP_LAND: r = 32'(a != 0 && b != 0);
        OP_OR:   r = w.left_operand | w.right_operand;
        OP_XOR:  r = w.left_operand ^ w.right_operand;
        OP_AND:  r = w.left_operand & w.right_operand;
        OP_EQ:   r = 32'(a == b);
        OP_NE:   r = 32'(a != b);
        OP_LE:   r = 32'(a <= b);
        OP_LT:   r = 32'(a < b);
        OP_GE:   r = 32'(a >= b);
        OP_GT:   r = 32'(a > b);
        OP_SHL: begin
          if (b < 0 || b > 31) e = ERR_SHIFT;
          else begin
            x = a <<< b[4:0];
            if (x > 64'sd2147483647 || x < -64'sd2147483648) e = ERR_OVF;
            else r = x[31:0];
          end
        end
        OP_SHR: begin
          if (b < 0 || b > 31) e = ERR_SHIFT;
          else r = w.left_operand >>> b[4:0];
        end
        OP_PASS: r = w.right_operand;
        default: r = '0;
      endcase
      if (e != ERR_NONE) r = '0;
      o.result_value = r;
      o.error_code = e;
      return o;
    endfunction

    function void note_word(in_word_t w);
      pending.insert(pending.size(), compute(w));
    endfunction

    function void check_response(out_word_t got);
      out_word_t want;
      if (pending.size() == 0) begin
        $error("unexpected response %h", got);
        failures++;
        return;
      end
      want = pending.pop_front();
      if (got.result_value !== want.result_value) begin
        $error("result_value: expected %0d, actual %0d", want.result_value,
               got.result_value);
        failures++;
      end
      if (got.error_code !== want.error_code) begin
        $error("error_code: expected %0d, actual %0d", want.error_code,
               got.error_code);
        failures++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  in_word_t  request = '0;
  logic      done;
  out_word_t response;
  alu_scoreboard board = new();
  int        cycles = 0;
  int        words_sent = 0;
  int        counts[32];
  int        n_err[4];
  int        n_unknown = 0;

  checked_int32_alu u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .request(request), .done(done), .response(response)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done) begin
      board.check_response(response);
      n_err[response.error_code]++;
    end
    if (!rst && start && !busy) begin
      board.note_word(request);
      counts[request.command]++;
    end
    if (cycles > 200000) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_word(logic [4:0] cmd, logic [31:0] a, logic [31:0] b);
    int gap;
    gap = (words_sent % 100 < 30) ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    request <= '{command: cmd, left_operand: a, right_operand: b};
    do @(posedge clk); while (busy);
    words_sent++;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return '0;
      4: return $urandom_range(0, 40);
      5: return -$urandom_range(0, 40);
      6: return $urandom >> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  logic [4:0]  cmd;
  logic [31:0] a, b;

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_word(OP_ADD, 32'h7fff_ffff, 32'd1);
    send_word(OP_SUB, 32'h8000_0000, 32'd1);
    send_word(OP_MUL, 32'h0001_0000, 32'h0000_8000);
    send_word(OP_MUL, 32'hffff_0000, 32'h0000_8000);
    send_word(OP_DIV, 32'd7, 32'd0);
    send_word(OP_DIV, 32'h8000_0000, 32'hffff_ffff);
    send_word(OP_MOD, 32'h8000_0000, 32'hffff_ffff);
    send_word(OP_DIV, -32'sd7, 32'd2);
    send_word(OP_MOD, -32'sd7, 32'd2);
    send_word(OP_LOR, 32'd0, 32'd0);
    send_word(OP_LAND, 32'd5, 32'h8000_0000);
    send_word(OP_OR, 32'hf0f0_f0f0, 32'h0f0f_0f0f);
    send_word(OP_XOR, 32'hffff_ffff, 32'h1234_5678);
    send_word(OP_AND, 32'hffff_ffff, 32'h8765_4321);
    send_word(OP_EQ, 32'h8000_0000, 32'h8000_0000);
    send_word(OP_NE, 32'd1, 32'd2);
    send_word(OP_LE, 32'h8000_0000, 32'h7fff_ffff);
    send_word(OP_LT, 32'h7fff_ffff, 32'h8000_0000);
    send_word(OP_GE, 32'd3, 32'd3);
    send_word(OP_GT, 32'hffff_ffff, 32'd0);
    send_word(OP_SHL, 32'd1, 32'd31);
    send_word(OP_SHL, 32'hffff_ffff, 32'd31);
    send_word(OP_SHL, 32'd1, 32'hffff_ffff);
    send_word(OP_SHR, 32'h8000_0000, 32'd32);
    send_word(OP_PASS, 32'd0, 32'h8000_0000);
    send_word(5'd31, 32'd9, 32'd9);
    repeat (950) begin
      cmd = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(19, 31)) :
                                            5'($urandom_range(0, 18));
      a = pick_value();
      b = pick_value();
      if ((cmd == OP_SHL || cmd == OP_SHR) && $urandom_range(0, 3) != 0)
        b = $urandom_range(0, 31);
      send_word(cmd, a, b);
    end
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    for (int i = 19; i < 32; i++) n_unknown += counts[i];
    $display("sent %0d words; divides %0d, shifts %0d, unknown opcodes %0d",
             words_sent, counts[OP_DIV] + counts[OP_MOD],
             counts[OP_SHL] + counts[OP_SHR], n_unknown);
    $display("errors seen: overflow %0d, zero divisor %0d, bad shift %0d",
             n_err[ERR_OVF], n_err[ERR_DIV0], n_err[ERR_SHIFT]);
    if (board.failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/ci32_pkg.sv
rtl/ci32_front.sv
rtl/ci32_mul.sv
rtl/ci32_div_stage.sv
rtl/ci32_back.sv
rtl/checked_int32_alu.sv
rtl/checked_int32_alu_checker.sv
tb/sv/testbench.sv
